// ----- rtl/core/udhrs_pkg.sv -----
// Package for the up/down hold-repeat setter: payload types, register indexes and constants.
`default_nettype none
package udhrs_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int VALUE_WIDTH = 8;
   localparam int HOLD_WIDTH  = 8;
   localparam int CSR_WIDTH   = 16;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
   localparam logic [HOLD_WIDTH-1:0]  HOLD_MAX  = {HOLD_WIDTH{1'b1}};

   localparam logic [VALUE_WIDTH-1:0] VALUE_RESET         = VALUE_WIDTH'(1);
   localparam logic [15:0]            DEBOUNCE_TICKS_RESET = 16'd150;
   localparam logic [15:0]            REPEAT_TICKS_RESET   = 16'd1000;
   localparam logic [15:0]            CONFIRM_TICKS_RESET  = 16'd1000;
   localparam logic [7:0]             FAST_AFTER_RESET     = 8'd5;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_REPEAT_TICKS   = 2'd1,
      CSR_CONFIRM_TICKS  = 2'd2,
      CSR_FAST_AFTER     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic up_pressed;
      logic down_pressed;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value_now;
      logic                   value_changed;
      logic                   chosen;
      logic                   confirm_pulse;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ----- rtl/core/up_down_hold_repeat_setter_unit.sv -----
// Up/down value setter: one tick per transaction, with debounce, auto-repeat and two-button confirm.
//
// Each request transaction is one timer tick carrying the up and down button levels; each
// tick gives exactly one response transaction with the value after that tick. The tick is
// folded into the timer and value state in the same cycle it is accepted and the result lands
// in an output register, so one tick is taken every clock cycle unless the response is stalled;
// a new tick is still taken while a response waits, as long as rsp_ready is high that
// cycle. The value starts at 1, floors at 0 and saturates at its maximum. Once both buttons
// have been held past confirm_ticks the chosen flag sticks and further ticks leave the
// value alone. CSR writes take effect on the next tick.
`default_nettype none
module up_down_hold_repeat_setter_unit
   import udhrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_data,
   input  wire logic             csr_we,
   input  wire csr_index_type    csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata
);

   // configuration
   logic [TIMER_WIDTH-1:0] debounce_ff, repeat_ff, confirm_ff;
   logic [HOLD_WIDTH-1:0]  fast_after_ff;

   // tick state
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   chosen_ff, chosen_in;
   logic [TIMER_WIDTH-1:0] up_el_ff, up_el_in, dn_el_ff, dn_el_in, both_el_ff, both_el_in;
   logic                   up_tim_ff, up_tim_in, up_lat_ff, up_lat_in;
   logic                   dn_tim_ff, dn_tim_in, dn_lat_ff, dn_lat_in;
   logic                   both_tim_ff, both_tim_in;
   logic [HOLD_WIDTH-1:0]  hold_ff, hold_in;

   // output register
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic [TIMER_WIDTH-1:0] up_adv, dn_adv, both_adv;
   logic [HOLD_WIDTH-1:0]  hold_inc;
   logic [VALUE_WIDTH:0]   up_sum;
   logic [VALUE_WIDTH-1:0] dn_step;
   logic                   pulse;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      value_in    = value_ff;
      chosen_in   = chosen_ff;
      up_el_in    = up_el_ff;
      up_tim_in   = up_tim_ff;
      up_lat_in   = up_lat_ff;
      dn_el_in    = dn_el_ff;
      dn_tim_in   = dn_tim_ff;
      dn_lat_in   = dn_lat_ff;
      both_el_in  = both_el_ff;
      both_tim_in = both_tim_ff;
      hold_in     = hold_ff;
      pulse       = 1'b0;
      up_sum      = '0;
      dn_step     = '0;

      // timers restart at zero, otherwise advance and saturate
      up_adv   = !up_tim_ff ? '0 : (up_el_ff == TIMER_MAX ? up_el_ff : up_el_ff + 1'b1);
      dn_adv   = !dn_tim_ff ? '0 : (dn_el_ff == TIMER_MAX ? dn_el_ff : dn_el_ff + 1'b1);
      both_adv = !both_tim_ff ? '0 :
                 (both_el_ff == TIMER_MAX ? both_el_ff : both_el_ff + 1'b1);
      hold_inc = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 1'b1;

      if (!chosen_ff) begin
         if (req_data.up_pressed && req_data.down_pressed) begin
            up_lat_in   = 1'b1;
            dn_lat_in   = 1'b1;
            up_tim_in   = 1'b0;
            up_el_in    = '0;
            dn_tim_in   = 1'b0;
            dn_el_in    = '0;
            hold_in     = '0;
            both_tim_in = 1'b1;
            both_el_in  = both_adv;
            if (both_adv > confirm_ff) begin
               chosen_in   = 1'b1;
               pulse       = 1'b1;
               both_tim_in = 1'b0;
               both_el_in  = '0;
            end
         end else begin
            both_tim_in = 1'b0;
            both_el_in  = '0;

            if (req_data.up_pressed) begin
               up_tim_in = 1'b1;
               up_el_in  = up_adv;
               if (!up_lat_ff && up_adv > debounce_ff) begin
                  up_sum    = {1'b0, value_ff} + 1'b1;
                  value_in  = up_sum[VALUE_WIDTH] ? VALUE_MAX : up_sum[VALUE_WIDTH-1:0];
                  up_lat_in = 1'b1;
                  up_el_in  = '0;
                  hold_in   = HOLD_WIDTH'(1);
               end else if (up_lat_ff && up_adv > repeat_ff) begin
                  // fast test uses the count before it advances
                  up_sum   = {1'b0, value_ff} +
                             ((hold_ff >= fast_after_ff) ? (VALUE_WIDTH+1)'(2)
                                                         : (VALUE_WIDTH+1)'(1));
                  value_in = up_sum[VALUE_WIDTH] ? VALUE_MAX : up_sum[VALUE_WIDTH-1:0];
                  up_el_in = '0;
                  hold_in  = hold_inc;
               end
            end else begin
               up_tim_in = 1'b0;
               up_el_in  = '0;
               up_lat_in = 1'b0;
            end

            if (req_data.down_pressed) begin
               dn_tim_in = 1'b1;
               dn_el_in  = dn_adv;
               if (!dn_lat_ff && dn_adv > debounce_ff) begin
                  dn_lat_in = 1'b1;
                  dn_el_in  = '0;
                  hold_in   = HOLD_WIDTH'(1);
                  value_in  = (value_ff != '0) ? value_ff - 1'b1 : value_ff;
               end else if (dn_lat_ff && dn_adv > repeat_ff) begin
                  // down side advances the count before the fast test
                  dn_el_in = '0;
                  hold_in  = hold_inc;
                  dn_step  = (hold_inc >= fast_after_ff) ? VALUE_WIDTH'(2) : VALUE_WIDTH'(1);
                  value_in = (value_ff > dn_step) ? value_ff - dn_step : '0;
               end
            end else begin
               dn_tim_in = 1'b0;
               dn_el_in  = '0;
               dn_lat_in = 1'b0;
            end

            if (!req_data.up_pressed && !req_data.down_pressed) begin
               hold_in = '0;
            end
         end
      end

      rsp_data_in.value_now     = value_in;
      rsp_data_in.value_changed = (value_in != value_ff);
      rsp_data_in.chosen        = chosen_in;
      rsp_data_in.confirm_pulse = pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_TICKS_RESET;
         repeat_ff     <= REPEAT_TICKS_RESET;
         confirm_ff    <= CONFIRM_TICKS_RESET;
         fast_after_ff <= FAST_AFTER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_TICKS: debounce_ff   <= csr_wdata[TIMER_WIDTH-1:0];
            CSR_REPEAT_TICKS:   repeat_ff     <= csr_wdata[TIMER_WIDTH-1:0];
            CSR_CONFIRM_TICKS:  confirm_ff    <= csr_wdata[TIMER_WIDTH-1:0];
            CSR_FAST_AFTER:     fast_after_ff <= csr_wdata[HOLD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff    <= VALUE_RESET;
         chosen_ff   <= 1'b0;
         up_el_ff    <= '0;
         up_tim_ff   <= 1'b0;
         up_lat_ff   <= 1'b0;
         dn_el_ff    <= '0;
         dn_tim_ff   <= 1'b0;
         dn_lat_ff   <= 1'b0;
         both_el_ff  <= '0;
         both_tim_ff <= 1'b0;
         hold_ff     <= '0;
      end else if (accept) begin
         value_ff    <= value_in;
         chosen_ff   <= chosen_in;
         up_el_ff    <= up_el_in;
         up_tim_ff   <= up_tim_in;
         up_lat_ff   <= up_lat_in;
         dn_el_ff    <= dn_el_in;
         dn_tim_ff   <= dn_tim_in;
         dn_lat_ff   <= dn_lat_in;
         both_el_ff  <= both_el_in;
         both_tim_ff <= both_tim_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // confirm pulse only ever comes with the chosen flag
   a_pulse_chosen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.confirm_pulse |-> rsp_data_ff.chosen)
      else $error("confirm pulse without chosen");

   // chosen is sticky until reset
   a_chosen_sticky: assert property (@(posedge clock) disable iff (reset)
      chosen_ff |=> chosen_ff)
      else $error("chosen flag dropped");

   // once chosen, ticks leave the value alone and report no change
   a_frozen_value: assert property (@(posedge clock) disable iff (reset)
      chosen_ff && accept |=> value_ff == $past(value_ff) && !rsp_data_ff.value_changed)
      else $error("value moved after confirmation");

endmodule
`default_nettype wire

// ----- tb/up_down_hold_repeat_setter_unit_tb.sv -----
// Testbench for the up/down hold-repeat setter: directed and random button ticks checked against a predictor.
`default_nettype none
module up_down_hold_repeat_setter_unit_tb;
   import udhrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PRINT_LIMIT = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE_TICKS;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   up_down_hold_repeat_setter_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted setter state and register copies
   logic [15:0] debounce_cfg = DEBOUNCE_TICKS_RESET;
   logic [15:0] repeat_cfg = REPEAT_TICKS_RESET;
   logic [15:0] confirm_cfg = CONFIRM_TICKS_RESET;
   logic [7:0] fast_cfg = FAST_AFTER_RESET;
   logic [7:0] value_q = VALUE_RESET;
   logic [7:0] hold_cnt = '0;
   logic [15:0] up_cnt = '0, dn_cnt = '0, both_cnt = '0;
   bit chosen_q = 1'b0;
   bit up_run = 1'b0, up_held = 1'b0, dn_run = 1'b0, dn_held = 1'b0, both_run = 1'b0;

   req_payload_type button_ticks[$];
   rsp_payload_type value_reports[$];
   int issued_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int both_len = 0;
   bit confirm_open = 1'b0;
   bit idle_en = 1'b1;
   bit sender_hold = 1'b0;
   int long_stall_req = 0;
   int stall_left = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   function automatic logic [15:0] timer_next(logic [15:0] cnt, bit running);
      if (!running) return '0;
      return (cnt == TIMER_MAX) ? cnt : cnt + 16'd1;
   endfunction

   function automatic logic [7:0] value_raise(logic [7:0] v, logic [1:0] n);
      logic [8:0] sum;
      sum = {1'b0, v} + 9'(n);
      return (sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : sum[7:0];
   endfunction

   function automatic rsp_payload_type settle_tick(req_payload_type t);
      rsp_payload_type r;
      logic [7:0] prior;
      prior = value_q;
      r.confirm_pulse = 1'b0;
      if (!chosen_q) begin
         if (t.up_pressed && t.down_pressed) begin
            up_held = 1'b1;
            dn_held = 1'b1;
            up_run = 1'b0;
            up_cnt = '0;
            dn_run = 1'b0;
            dn_cnt = '0;
            hold_cnt = '0;
            both_cnt = timer_next(both_cnt, both_run);
            both_run = 1'b1;
            if (both_cnt > confirm_cfg) begin
               chosen_q = 1'b1;
               r.confirm_pulse = 1'b1;
               both_run = 1'b0;
               both_cnt = '0;
            end
         end else begin
            both_run = 1'b0;
            both_cnt = '0;
            if (t.up_pressed) begin
               up_cnt = timer_next(up_cnt, up_run);
               up_run = 1'b1;
               if (!up_held && up_cnt > debounce_cfg) begin
                  value_q = value_raise(value_q, 2'd1);
                  up_held = 1'b1;
                  up_cnt = '0;
                  hold_cnt = 8'd1;
               end else if (up_held && up_cnt > repeat_cfg) begin
                  // fast test uses the count before it advances
                  value_q = value_raise(value_q, (hold_cnt >= fast_cfg) ? 2'd2 : 2'd1);
                  up_cnt = '0;
                  if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 8'd1;
               end
            end else begin
               up_run = 1'b0;
               up_cnt = '0;
               up_held = 1'b0;
            end
            if (t.down_pressed) begin
               dn_cnt = timer_next(dn_cnt, dn_run);
               dn_run = 1'b1;
               if (!dn_held && dn_cnt > debounce_cfg) begin
                  dn_held = 1'b1;
                  dn_cnt = '0;
                  hold_cnt = 8'd1;
                  if (value_q != '0) value_q = value_q - 8'd1;
               end else if (dn_held && dn_cnt > repeat_cfg) begin
                  // down advances the hold count before the fast test
                  dn_cnt = '0;
                  if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 8'd1;
                  if (hold_cnt >= fast_cfg && value_q != '0) value_q = value_q - 8'd1;
                  if (value_q != '0) value_q = value_q - 8'd1;
               end
            end else begin
               dn_run = 1'b0;
               dn_cnt = '0;
               dn_held = 1'b0;
            end
            if (!t.up_pressed && !t.down_pressed) hold_cnt = '0;
         end
      end
      r.value_now = value_q;
      r.value_changed = (value_q != prior);
      r.chosen = chosen_q;
      return r;
   endfunction

   task report_mismatch(string what, int got, int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // driver: one tick per transaction, optional gap after each
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!sender_hold && button_ticks.size() != 0) begin
            req_data <= button_ticks.pop_front();
            req_valid <= 1'b1;
            req_gap = idle_en ? int'($urandom_range(0, 3)) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (long_stall_req != 0) begin
         stall_left = long_stall_req;
         long_stall_req = 0;
      end
      if (rsp_taken) rsp_gap = idle_en ? int'($urandom_range(0, 3)) : 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            value_reports.push_back(settle_tick(req_data));
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (value_reports.size() == 0) begin
               report_mismatch("unexpected transaction, value_now", rsp_data.value_now, -1);
            end else begin
               want = value_reports.pop_front();
               if (rsp_data.value_now !== want.value_now)
                  report_mismatch("value_now", rsp_data.value_now, want.value_now);
               if (rsp_data.value_changed !== want.value_changed)
                  report_mismatch("value_changed", rsp_data.value_changed, want.value_changed);
               if (rsp_data.chosen !== want.chosen)
                  report_mismatch("chosen", rsp_data.chosen, want.chosen);
               if (rsp_data.confirm_pulse !== want.confirm_pulse)
                  report_mismatch("confirm_pulse", rsp_data.confirm_pulse, want.confirm_pulse);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("[up_down_hold_repeat_setter_unit] ERROR");
      $finish;
   end

   task add_tick(bit up, bit dn);
      req_payload_type t;
      // keep both-button runs short of a confirm until the final phase
      if (up && dn && !confirm_open && both_len >= int'(confirm_cfg) + 1) dn = 1'b0;
      both_len = (up && dn) ? both_len + 1 : 0;
      t.up_pressed = up;
      t.down_pressed = dn;
      button_ticks.push_back(t);
      issued_count++;
   endtask

   task add_hold(bit up, bit dn, int len);
      repeat (len) add_tick(up, dn);
   endtask

   task add_random(int n);
      int goal, base, both_span, pick;
      bit btn;
      goal = issued_count + n;
      base = int'(debounce_cfg) + 6 * (int'(repeat_cfg) + 1) + 2;
      if (base > 300) base = 300;
      both_span = int'(confirm_cfg) + 1;
      if (both_span > 20) both_span = 20;
      while (issued_count < goal) begin
         pick = $urandom_range(0, 99);
         btn = 1'($urandom_range(0, 1));
         if (pick < 20) begin
            add_hold(1'b1, 1'b0, $urandom_range(1, base));
         end else if (pick < 40) begin
            add_hold(1'b0, 1'b1, $urandom_range(1, base));
         end else if (pick < 50) begin
            add_hold(1'b0, 1'b0, $urandom_range(1, 3));
         end else if (pick < 65) begin
            // both held, then one released while the other stays down
            add_hold(1'b1, 1'b1, $urandom_range(1, both_span));
            add_hold(btn, !btn, $urandom_range(1, base));
         end else if (pick < 75) begin
            add_hold(btn, !btn, (base < 40) ? int'($urandom_range(100, 300)) : base);
         end else if (pick < 85) begin
            add_hold(btn, !btn, $urandom_range(1, base));
            add_hold(!btn, btn, $urandom_range(1, base));
         end else begin
            repeat ($urandom_range(1, 8))
               add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task write_reg(csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_TICKS: debounce_cfg = data;
         CSR_REPEAT_TICKS:   repeat_cfg = data;
         CSR_CONFIRM_TICKS:  confirm_cfg = data;
         CSR_FAST_AFTER:     fast_cfg = data[7:0];
         default: ;
      endcase
   endtask

   task set_config(int dbn, int rpt, int cfm, int fst, bit idle);
      write_reg(CSR_DEBOUNCE_TICKS, 16'(dbn));
      write_reg(CSR_REPEAT_TICKS, 16'(rpt));
      write_reg(CSR_CONFIRM_TICKS, 16'(cfm));
      write_reg(CSR_FAST_AFTER, 16'(fst));
      @(posedge clock);
      idle_en = idle;
   endtask

   // waits until every tick is taken and every result checked
   task drain;
      do @(negedge clock);
      while (accepted_count != issued_count || value_reports.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   initial begin : stimulus
      int mark;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first step lands after the default debounce
      add_hold(1'b1, 1'b0, 152);
      add_tick(1'b0, 1'b0);
      add_tick(1'b1, 1'b1);
      drain();

      // short directed run: floor at zero, fast repeat, both then one
      set_config(1, 1, 3, 2, 1'b1);
      add_hold(1'b0, 1'b1, 6);
      add_tick(1'b0, 1'b0);
      add_hold(1'b1, 1'b1, 4);
      add_hold(1'b1, 1'b0, 4);
      add_hold(1'b0, 1'b1, 2);
      add_tick(1'b1, 1'b0);
      add_hold(1'b0, 1'b0, 2);
      add_hold(1'b1, 1'b0, 8);
      add_tick(1'b0, 1'b0);
      drain();

      // lowest settings, no idling: saturation at the top
      set_config(0, 0, 0, 1, 1'b0);
      add_hold(1'b1, 1'b0, 270);
      add_hold(1'b0, 1'b1, 20);
      add_random(40);
      drain();

      // zero fast threshold, with a long receiver hold-off and a sender pause
      set_config(2, 3, 4, 0, 1'b1);
      mark = accepted_count;
      add_random(120);
      wait (accepted_count >= mark + 30);
      long_stall_req = 40;
      wait (accepted_count >= mark + 90);
      sender_hold = 1'b1;
      do @(negedge clock);
      while (req_valid || value_reports.size() != 0);
      repeat (4) @(negedge clock);
      @(posedge clock);
      sender_hold = 1'b0;
      drain();

      set_config(3, 2, 5, 255, 1'b1);
      add_random(60);
      drain();

      // debounce longer than the repeat period
      set_config(10, 2, 6, 4, 1'b1);
      add_random(80);
      drain();

      // confirm, then ticks that must be ignored
      set_config(1, 1, 2, 3, 1'b1);
      add_random(20);
      confirm_open = 1'b1;
      add_hold(1'b1, 1'b1, 4);
      repeat (12) add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      drain();

      repeat (5) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[up_down_hold_repeat_setter_unit] OK");
      end else begin
         $display("[up_down_hold_repeat_setter_unit] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
